>>> rtl/core/ecm_pkg.sv
// Shared constants, tables and types for the elevation colormap pipeline.
// No dependencies; used by every module under rtl/core.
package ecm_pkg;

   localparam int ELEV_FRAC_BITS = 4;
   localparam int ELEV_W         = 19;
   localparam int SCALE          = 1 << ELEV_FRAC_BITS;

   localparam int NUM_STOPS = 6;
   localparam int NUM_SEG   = NUM_STOPS - 1;
   localparam int SEG_W     = 3;
   localparam int CH_W      = 2;
   localparam int COLOR_W   = 8;

   // Color stops in whole metres.
   localparam int STOP_M [NUM_STOPS] = '{0, 300, 900, 1800, 2700, 3800};
   localparam int SPAN_MIN_M = 300;
   localparam int SPAN_MAX_M = 1100;
   localparam int NODATA_M   = 9000;

   // Quotient of the rounding division is offset so it is never negative.
   localparam int Q_W       = COLOR_W + 1;
   localparam int Q_BIAS    = 1 << COLOR_W;

   localparam int X_W       = $clog2(SPAN_MAX_M * SCALE);
   localparam int DC_W      = COLOR_W + 1;
   localparam int PROD_W    = X_W + DC_W + 1;
   localparam int DIV_W     = $clog2(2 * SPAN_MAX_M * SCALE + 1);
   localparam int T_W       = $clog2(4 * Q_BIAS * SPAN_MAX_M * SCALE);
   localparam int RECIP_SH  = T_W;
   localparam int RECIP_W   = $clog2((1 << RECIP_SH) / (2 * SPAN_MIN_M * SCALE) + 1);
   localparam int REM_W     = DIV_W + 1;

   localparam logic signed [ELEV_W-1:0] NODATA_E = ELEV_W'(-(NODATA_M * SCALE));

   localparam logic signed [ELEV_W-1:0] STOP_E [NUM_STOPS] = '{
      ELEV_W'(STOP_M[0] * SCALE), ELEV_W'(STOP_M[1] * SCALE), ELEV_W'(STOP_M[2] * SCALE),
      ELEV_W'(STOP_M[3] * SCALE), ELEV_W'(STOP_M[4] * SCALE), ELEV_W'(STOP_M[5] * SCALE)
   };

   localparam int SPAN0 = (STOP_M[1] - STOP_M[0]) * SCALE;
   localparam int SPAN1 = (STOP_M[2] - STOP_M[1]) * SCALE;
   localparam int SPAN2 = (STOP_M[3] - STOP_M[2]) * SCALE;
   localparam int SPAN3 = (STOP_M[4] - STOP_M[3]) * SCALE;
   localparam int SPAN4 = (STOP_M[5] - STOP_M[4]) * SCALE;

   // Divisor of the rounding division: twice the segment span.
   localparam logic [DIV_W-1:0] DIV_TAB [NUM_SEG] = '{
      DIV_W'(2 * SPAN0), DIV_W'(2 * SPAN1), DIV_W'(2 * SPAN2),
      DIV_W'(2 * SPAN3), DIV_W'(2 * SPAN4)
   };

   // Rounding half plus the bias that keeps the dividend positive.
   localparam logic [T_W-1:0] OFF_TAB [NUM_SEG] = '{
      T_W'((2 * Q_BIAS + 1) * SPAN0), T_W'((2 * Q_BIAS + 1) * SPAN1),
      T_W'((2 * Q_BIAS + 1) * SPAN2), T_W'((2 * Q_BIAS + 1) * SPAN3),
      T_W'((2 * Q_BIAS + 1) * SPAN4)
   };

   // Truncated reciprocals; the estimate is low by at most one.
   localparam logic [RECIP_W-1:0] RECIP_TAB [NUM_SEG] = '{
      RECIP_W'((1 << RECIP_SH) / (2 * SPAN0)), RECIP_W'((1 << RECIP_SH) / (2 * SPAN1)),
      RECIP_W'((1 << RECIP_SH) / (2 * SPAN2)), RECIP_W'((1 << RECIP_SH) / (2 * SPAN3)),
      RECIP_W'((1 << RECIP_SH) / (2 * SPAN4))
   };

   localparam logic [COLOR_W-1:0] STOP_RGB [NUM_STOPS][3] = '{
      '{8'd232, 8'd245, 8'd200},
      '{8'd168, 8'd208, 8'd141},
      '{8'd106, 8'd168, 8'd79},
      '{8'd181, 8'd101, 8'd29},
      '{8'd139, 8'd115, 8'd85},
      '{8'd240, 8'd235, 8'd227}
   };

   localparam logic [COLOR_W-1:0] NODATA_RGB [3] = '{8'd26, 8'd79, 8'd114};
   localparam logic [COLOR_W-1:0] COAST_RGB  [3] = '{8'd91, 8'd163, 8'd201};

   localparam logic [CH_W-1:0] CH_RED   = 2'd0;
   localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
   localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_NODATA,
      KIND_COAST,
      KIND_SUMMIT,
      KIND_RAMP
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [SEG_W-1:0] seg;
   } ctl_type;

endpackage

>>> rtl/core/elevation_colormap.sv
// Top level of the elevation colormap: six-stage pipeline with valid bits.
// Depends on ecm_pkg, ecm_classify and ecm_channel.
//
// Usage: each word on the req channel carries one signed elevation sample
// in sixteenths of a metre; each word on the rsp channel carries the RGB
// pixel for it, in the same order, one pixel per sample. Samples below
// -9000 m get the no-data color, samples at or below 0 m the coast color,
// samples at or above 3800 m the summit color, and the rest are blended
// linearly between color stops with round-half-up.
// Throughput is one word per cycle while rsp_tready stays high:
// classification, the channel multiply, the biased dividend, the reciprocal
// multiply, the remainder check and the output register each take one stage.
// When the receiver holds rsp_tready low, the stages fill one by one and
// req_tready drops only once every stage holds a word; nothing is lost or
// repeated. Reset empties the pipeline; rsp_tvalid is low afterward.
module elevation_colormap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [18:0] elevation, [23:19] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

   localparam int NUM_STAGES = 6;

   logic [NUM_STAGES:1]   valid_ff, valid_in;
   logic [NUM_STAGES+1:1] rdy;

   ecm_pkg::ctl_type                 ctl_in, ctl1_ff;
   logic [ecm_pkg::X_W-1:0]          x_in, x1_ff;
   ecm_pkg::kind_type                kind2_ff, kind3_ff, kind4_ff, kind5_ff;
   logic [ecm_pkg::COLOR_W-1:0]      red_mix, green_mix, blue_mix;
   logic [ecm_pkg::COLOR_W-1:0]      red_in, green_in, blue_in;
   logic [ecm_pkg::COLOR_W-1:0]      red_ff, green_ff, blue_ff;

   // A stage takes a new word when it is empty or its word moves on.
   always_comb begin
      rdy[NUM_STAGES+1] = rsp_tready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[1] = rdy[1] ? req_tvalid : valid_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   ecm_classify u_classify (
      .elevation (req_tdata[ecm_pkg::ELEV_W-1:0]),
      .ctl       (ctl_in),
      .x_offset  (x_in)
   );

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ctl1_ff <= ctl_in;
         x1_ff   <= x_in;
      end
      if (rdy[2]) begin
         kind2_ff <= ctl1_ff.kind;
      end
      if (rdy[3]) begin
         kind3_ff <= kind2_ff;
      end
      if (rdy[4]) begin
         kind4_ff <= kind3_ff;
      end
      if (rdy[5]) begin
         kind5_ff <= kind4_ff;
      end
      if (rdy[6]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   ecm_channel u_red (
      .clock    (clock),
      .stage_en (rdy[5:2]),
      .ch       (ecm_pkg::CH_RED),
      .seg      (ctl1_ff.seg),
      .x_offset (x1_ff),
      .value    (red_mix)
   );

   ecm_channel u_green (
      .clock    (clock),
      .stage_en (rdy[5:2]),
      .ch       (ecm_pkg::CH_GREEN),
      .seg      (ctl1_ff.seg),
      .x_offset (x1_ff),
      .value    (green_mix)
   );

   ecm_channel u_blue (
      .clock    (clock),
      .stage_en (rdy[5:2]),
      .ch       (ecm_pkg::CH_BLUE),
      .seg      (ctl1_ff.seg),
      .x_offset (x1_ff),
      .value    (blue_mix)
   );

   always_comb begin
      case (kind5_ff)
         ecm_pkg::KIND_NODATA: begin
            red_in   = ecm_pkg::NODATA_RGB[0];
            green_in = ecm_pkg::NODATA_RGB[1];
            blue_in  = ecm_pkg::NODATA_RGB[2];
         end
         ecm_pkg::KIND_COAST: begin
            red_in   = ecm_pkg::COAST_RGB[0];
            green_in = ecm_pkg::COAST_RGB[1];
            blue_in  = ecm_pkg::COAST_RGB[2];
         end
         ecm_pkg::KIND_SUMMIT: begin
            red_in   = ecm_pkg::STOP_RGB[ecm_pkg::NUM_STOPS-1][0];
            green_in = ecm_pkg::STOP_RGB[ecm_pkg::NUM_STOPS-1][1];
            blue_in  = ecm_pkg::STOP_RGB[ecm_pkg::NUM_STOPS-1][2];
         end
         default: begin
            red_in   = red_mix;
            green_in = green_mix;
            blue_in  = blue_mix;
         end
      endcase
   end

   assign req_tready = rdy[1];
   assign rsp_tvalid = valid_ff[NUM_STAGES];
   assign rsp_tdata  = {blue_ff, green_ff, red_ff};

endmodule

>>> rtl/core/ecm_classify.sv
// Sorts an elevation sample into its color class and ramp segment.
// Depends on ecm_pkg for the stop elevations and types.
module ecm_classify (
   input  logic signed [ecm_pkg::ELEV_W-1:0] elevation,
   output ecm_pkg::ctl_type                  ctl,
   output logic [ecm_pkg::X_W-1:0]           x_offset
);

   logic [ecm_pkg::SEG_W-1:0]        seg;
   logic signed [ecm_pkg::ELEV_W-1:0] diff;

   always_comb begin
      seg = '0;
      for (int i = 1; i < ecm_pkg::NUM_SEG; i++) begin
         if (elevation >= ecm_pkg::STOP_E[i]) begin
            seg = ecm_pkg::SEG_W'(i);
         end
      end
      diff     = elevation - ecm_pkg::STOP_E[seg];
      x_offset = diff[ecm_pkg::X_W-1:0];

      ctl.seg = seg;
      if (elevation < ecm_pkg::NODATA_E) begin
         ctl.kind = ecm_pkg::KIND_NODATA;
      end else if (elevation <= $signed(ecm_pkg::ELEV_W'(0))) begin
         ctl.kind = ecm_pkg::KIND_COAST;
      end else if (elevation >= ecm_pkg::STOP_E[ecm_pkg::NUM_STOPS-1]) begin
         ctl.kind = ecm_pkg::KIND_SUMMIT;
      end else begin
         ctl.kind = ecm_pkg::KIND_RAMP;
      end
   end

endmodule

>>> rtl/core/ecm_channel.sv
// Four-stage interpolation of one color channel: product, biased dividend,
// reciprocal estimate, remainder correction. Depends on ecm_pkg tables.
module ecm_channel (
   input  logic                          clock,
   input  logic [3:0]                    stage_en,
   input  logic [ecm_pkg::CH_W-1:0]      ch,
   input  logic [ecm_pkg::SEG_W-1:0]     seg,
   input  logic [ecm_pkg::X_W-1:0]       x_offset,
   output logic [ecm_pkg::COLOR_W-1:0]   value
);

   logic signed [ecm_pkg::DC_W-1:0]      dc;
   logic signed [ecm_pkg::PROD_W-1:0]    prod_in, prod_ff;
   logic [ecm_pkg::SEG_W-1:0]            seg2_ff, seg3_ff, seg4_ff, seg5_ff;
   logic signed [ecm_pkg::T_W+1:0]       t_wide;
   logic [ecm_pkg::T_W-1:0]              t_in, t3_ff, t4_ff;
   logic [ecm_pkg::T_W+ecm_pkg::RECIP_W-1:0] qe_wide;
   logic [ecm_pkg::Q_W-1:0]              qe_in, qe4_ff, qe5_ff;
   logic [ecm_pkg::T_W-1:0]              back;
   logic [ecm_pkg::T_W-1:0]              rem_full;
   logic [ecm_pkg::REM_W-1:0]            rem_in, rem5_ff;
   logic [ecm_pkg::Q_W-1:0]              q;
   logic [ecm_pkg::COLOR_W+1:0]          sum;

   always_comb begin
      dc = $signed({1'b0, ecm_pkg::STOP_RGB[seg + 1'b1][ch]})
         - $signed({1'b0, ecm_pkg::STOP_RGB[seg][ch]});
      prod_in = $signed({1'b0, x_offset}) * dc;

      t_wide = (ecm_pkg::T_W+2)'($signed({prod_ff, 1'b0}))
             + (ecm_pkg::T_W+2)'({1'b0, ecm_pkg::OFF_TAB[seg2_ff]});
      t_in = t_wide[ecm_pkg::T_W-1:0];

      qe_wide = t3_ff * ecm_pkg::RECIP_TAB[seg3_ff];
      qe_in   = qe_wide[ecm_pkg::RECIP_SH +: ecm_pkg::Q_W];

      back     = ecm_pkg::T_W'(qe4_ff * ecm_pkg::DIV_TAB[seg4_ff]);
      rem_full = t4_ff - back;
      rem_in   = rem_full[ecm_pkg::REM_W-1:0];

      // The reciprocal estimate is at most one low; the remainder fixes it.
      q = qe5_ff + ecm_pkg::Q_W'(rem5_ff >= {1'b0, ecm_pkg::DIV_TAB[seg5_ff]});
      sum = {2'b00, ecm_pkg::STOP_RGB[seg5_ff][ch]} + {1'b0, q}
          - (ecm_pkg::COLOR_W+2)'(ecm_pkg::Q_BIAS);
      value = sum[ecm_pkg::COLOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
         seg2_ff <= seg;
      end
      if (stage_en[1]) begin
         t3_ff   <= t_in;
         seg3_ff <= seg2_ff;
      end
      if (stage_en[2]) begin
         qe4_ff  <= qe_in;
         t4_ff   <= t3_ff;
         seg4_ff <= seg3_ff;
      end
      if (stage_en[3]) begin
         rem5_ff <= rem_in;
         qe5_ff  <= qe4_ff;
         seg5_ff <= seg4_ff;
      end
   end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for elevation_colormap: drives elevation words with bursty
// flow control, stalls the pixel side, and checks every pixel against a local predictor.
// Depends only on the elevation_colormap RTL and its package.
module tb;

   localparam int FRAC_BITS     = 4;
   localparam int UNIT          = 1 << FRAC_BITS;
   localparam int NO_DATA_FLOOR = -9000 * UNIT;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 16;

   // Ramp stops in whole metres and their colors, red/green/blue.
   localparam int RAMP_M [6] = '{0, 300, 900, 1800, 2700, 3800};
   localparam int RAMP_RGB [6][3] = '{
      '{232, 245, 200},
      '{168, 208, 141},
      '{106, 168, 79},
      '{181, 101, 29},
      '{139, 115, 85},
      '{240, 235, 227}
   };
   localparam int DEEP_SEA_RGB [3] = '{26, 79, 114};
   localparam int COAST_RGB [3]    = '{91, 163, 201};

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct {
      logic [18:0] elevation;
      pixel_type   pixel;
   } pending_pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [18:0] elevation, [23:19] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] red, [15:8] green, [23:16] blue

   pending_pixel_type expected_pixels [$];
   int error_count = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   int gap_max     = 8;

   elevation_colormap i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Blend one channel between two stops with round-half-up, exactly in integers.
   function automatic int blend_channel(int c0, int c1, longint x, longint span);
      longint num;
      num = 2 * longint'(c0) * span + 2 * x * longint'(c1 - c0) + span;
      return int'(num / (2 * span));
   endfunction

   function automatic pixel_type map_elevation(logic [18:0] raw);
      longint    e;
      longint    lo;
      longint    span;
      int        seg;
      int        rgb [3];
      pixel_type px;
      e = longint'($signed(raw));
      if (e < NO_DATA_FLOOR) begin
         rgb = DEEP_SEA_RGB;
      end else if (e <= 0) begin
         rgb = COAST_RGB;
      end else if (e >= RAMP_M[5] * UNIT) begin
         rgb = RAMP_RGB[5];
      end else begin
         seg = 0;
         while (seg < 4 && e >= RAMP_M[seg + 1] * UNIT) seg++;
         lo   = RAMP_M[seg] * UNIT;
         span = (RAMP_M[seg + 1] - RAMP_M[seg]) * UNIT;
         for (int ch = 0; ch < 3; ch++)
            rgb[ch] = blend_channel(RAMP_RGB[seg][ch], RAMP_RGB[seg + 1][ch], e - lo, span);
      end
      px.red   = rgb[0][7:0];
      px.green = rgb[1][7:0];
      px.blue  = rgb[2][7:0];
      return px;
   endfunction

   // Input and output monitor; the prediction is queued before the pop so order holds.
   always @(posedge clock) begin
      pending_pixel_type want;
      pixel_type         got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_pixels.push_back('{req_tdata[18:0], map_elevation(req_tdata[18:0])});
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: pixel r=%0d g=%0d b=%0d with no word pending",
                           got.red, got.green, got.blue);
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.pixel.red || got.green !== want.pixel.green ||
                   got.blue !== want.pixel.blue) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: elevation %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              $signed(want.elevation), want.pixel.red, want.pixel.green,
                              want.pixel.blue, got.red, got.green, got.blue);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("elevation_colormap verification failed");
            $finish;
         end
      end
   end

   // Receiver stall pattern: switches between always ready, light, heavy and periodic stalls.
   initial begin
      int mode;
      int mode_left;
      int tick;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_tready <= ((tick % 11) < 4);
            end
         endcase
      end
   end

   // Sends one elevation word; a new burst starts after a random gap.
   task automatic send_elevation(input logic [18:0] raw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Region edges, stop points, their neighbors and the field extremes.
   task automatic test_regions_and_stops();
      int points [$];
      points = '{-262144, 262143, NO_DATA_FLOOR - 1, NO_DATA_FLOOR, NO_DATA_FLOOR + 1,
                 -1, 0, 1, 4799, 4800, 4801, 9600, 14400, 21600, 28800, 36000,
                 43200, 52000, 60799, 60800, 60801, 8};
      foreach (points[i]) send_elevation(19'(points[i]));
   endtask

   // Most samples fall inside the ramp, where the arithmetic is.
   task automatic test_ramp_random(input int count);
      repeat (count) send_elevation(19'($urandom_range(1, RAMP_M[5] * UNIT - 1)));
   endtask

   // Any 19-bit pattern, so every bit of the field toggles.
   task automatic test_full_range_random(input int count);
      repeat (count) send_elevation(19'($urandom_range(0, (1 << 19) - 1)));
   endtask

   // Samples a few units around each region boundary and inner stop.
   task automatic test_near_boundaries(input int count);
      int edges [7];
      int offset;
      edges = '{NO_DATA_FLOOR, 0, 4800, 14400, 28800, 43200, 60800};
      repeat (count) begin
         offset = $urandom_range(0, 8);
         send_elevation(19'(edges[$urandom_range(0, 6)] + offset - 4));
      end
   endtask

   // Words back to back so that full throughput meets receiver stalls.
   task automatic test_back_to_back(input int count);
      int saved_gap_max;
      saved_gap_max = gap_max;
      gap_max = 0;
      test_ramp_random(count);
      gap_max = saved_gap_max;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_regions_and_stops();
      test_ramp_random(450);
      test_full_range_random(250);
      test_near_boundaries(100);
      test_back_to_back(120);

      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("elevation_colormap verification clean");
      end else begin
         $display("elevation_colormap verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/ecm_pkg.sv
rtl/core/ecm_classify.sv
rtl/core/ecm_channel.sv
rtl/core/elevation_colormap.sv
tb/sv/tb.sv
